// ----- src/srms_pkg.sv -----
// ----------------------------------------------------------------------------
// srms_pkg
// Shared types, codes and helpers of the strain-rate magnitude stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package srms_pkg;

  // command codes
  localparam logic [2:0] CMD_VEL     = 3'd0;
  localparam logic [2:0] CMD_CSI     = 3'd1;
  localparam logic [2:0] CMD_ETA     = 3'd2;
  localparam logic [2:0] CMD_ZET     = 3'd3;
  localparam logic [2:0] CMD_JAC     = 3'd4;
  localparam logic [2:0] CMD_COMPUTE = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_EDGE = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // configuration register indexes
  localparam int         CFG_IDX_W    = 2;
  localparam logic [1:0] REG_SIZE_X   = 2'd0;
  localparam logic [1:0] REG_SIZE_Y   = 2'd1;
  localparam logic [1:0] REG_SIZE_Z   = 2'd2;
  localparam logic [1:0] REG_INV_RE   = 2'd3;

  // width holding any grid extent up to 256
  localparam int DIM_W = 9;
  // width of the saturation input and of the invariant accumulator
  localparam int SAT_W = 52;
  // width of the non-negative invariant handed to the root unit
  localparam int INV_W = 51;
  // mask values above this are solid
  localparam logic [2:0] MASK_FLUID_MAX = 3'd2;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic        [3:0]  cell_x;
    logic        [3:0]  cell_y;
    logic        [3:0]  cell_z;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic        [2:0]  solid_mask;
  } in_item_t;

  typedef struct packed {
    logic [31:0] strain_magnitude;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // root unit request and response
  typedef struct packed {
    logic             start;
    logic [INV_W-1:0] value;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic        big;
    logic [31:0] mag;
  } root_rsp_t;

  // clamp to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SAT_W-1:31];
    hi_zeros = ~|v[SAT_W-1:31];
    r.ovf = !(hi_ones || hi_zeros);
    if (r.ovf) begin
      r.val = v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // size register to extent in use
  function automatic logic [DIM_W-1:0] clamp_size(input logic [4:0] v,
                                                  input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] e;
    e = DIM_W'(v);
    if (e < DIM_W'(3)) return DIM_W'(3);
    if (e > lim) return lim;
    return e;
  endfunction

  // flat index of a 3x3 element
  function automatic logic [3:0] idx3(input logic [1:0] a, input logic [1:0] b);
    return {1'b0, a, 1'b0} + {2'b00, a} + {2'b00, b};
  endfunction

endpackage

`default_nettype wire

// ----- src/srms_ram.sv -----
// ----------------------------------------------------------------------------
// srms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/srms_mul.sv -----
// ----------------------------------------------------------------------------
// srms_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed      [65:0] p
);

  // one product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ----- src/srms_root.sv -----
// ----------------------------------------------------------------------------
// srms_root
// Divides the invariant by three, four bits a cycle, then takes the integer
// square root of the quotient in Q16.16, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_root (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srms_pkg::root_req_t req,
  output srms_pkg::root_rsp_t      rsp
);

  localparam int DIV_W      = srms_pkg::INV_W + 1;
  localparam int DIV_STEPS  = DIV_W / 4;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_SQRT = 4'b0100,
    R_DONE = 4'b1000
  } root_state_t;

  root_state_t       state;
  logic [4:0]        cnt;
  logic [DIV_W-1:0]  w;
  logic [1:0]        r;
  logic [63:0]       rad;
  logic [33:0]       rem;
  logic [31:0]       root;
  logic              big;

  logic [DIV_W-1:0]  w_next;
  logic [1:0]        r_next;
  logic [33:0]       rem_next;
  logic [31:0]       root_next;

  // four restoring steps of division by three
  always_comb begin
    logic [2:0] t;
    w_next = w;
    r_next = r;
    for (int i = 0; i < 4; i++) begin
      t      = {r_next, w_next[DIV_W-1]};
      w_next = {w_next[DIV_W-2:0], (t >= 3'd3)};
      r_next = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end
  end

  // one digit of the square root
  always_comb begin
    logic [35:0] rem_t;
    logic [35:0] trial;
    rem_t = {rem, rad[63:62]};
    trial = {2'b00, root, 2'b01};
    if (rem_t >= trial) begin
      rem_next  = 34'(rem_t - trial);
      root_next = {root[30:0], 1'b1};
    end else begin
      rem_next  = rem_t[33:0];
      root_next = {root[30:0], 1'b0};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        R_IDLE: begin
          if (req.start) begin
            w     <= {1'b0, req.value};
            r     <= '0;
            cnt   <= '0;
            state <= R_DIV;
          end
        end
        R_DIV: begin
          w   <= w_next;
          r   <= r_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) begin
            cnt <= '0;
            if (|w_next[DIV_W-1:48]) begin
              big   <= 1'b1;
              state <= R_DONE;
            end else begin
              big   <= 1'b0;
              rad   <= {w_next[47:0], 16'h0000};
              rem   <= '0;
              root  <= '0;
              state <= R_SQRT;
            end
          end
        end
        R_SQRT: begin
          rad  <= {rad[61:0], 2'b00};
          rem  <= rem_next;
          root <= root_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            state <= R_DONE;
          end
        end
        R_DONE: begin
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (state == R_DONE);
  assign rsp.big  = big;
  assign rsp.mag  = root;

endmodule

`default_nettype wire

// ----- src/strain_rate_magnitude_stencil.sv -----
// ----------------------------------------------------------------------------
// strain_rate_magnitude_stencil
// Per-cell stores of velocity, face metrics, jacobian and solid mask, and a
// compute sequence that returns the scaled strain-rate magnitude of a cell.
// ----------------------------------------------------------------------------
//
//  channel  signals                          direction  transfer when
//  item     item_valid item_stall item       in         valid & !stall
//  result   result_valid result_stall result out        valid & !stall
//  cfg      cfg_write cfg_index cfg_data     in         cfg_write
//
// A compute of a cell off the interior goes straight to write-back. An
// interior compute runs seven stencil reads, 51 products through the one
// shared multiplier, and the serial divide-by-three and, unless the
// quotient saturates, the square root of the root unit.
// Reset is synchronous; the stores are not cleared and hold nothing useful
// until loaded. Items are stalled while a compute is in flight; a finished
// result waits in the output register while loads carry on.
// ----------------------------------------------------------------------------
`default_nettype none

module strain_rate_magnitude_stencil #(
  parameter int GRID_MAX_X = 16,
  parameter int GRID_MAX_Y = 16,
  parameter int GRID_MAX_Z = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire srms_pkg::in_item_t                   item,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output srms_pkg::out_item_t                       result,
  input  wire logic                                 cfg_write,
  input  wire logic [srms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                          cfg_data
);

  localparam int DEPTH = GRID_MAX_X * GRID_MAX_Y * GRID_MAX_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = srms_pkg::DIM_W;
  localparam logic [AW-1:0] STR_X = AW'(1);
  localparam logic [AW-1:0] STR_Y = AW'(GRID_MAX_X);
  localparam logic [AW-1:0] STR_Z = AW'(GRID_MAX_X * GRID_MAX_Y);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_GRAD = 9'b000000100,
    S_MET  = 9'b000001000,
    S_DIF  = 9'b000010000,
    S_SCL  = 9'b000100000,
    S_INV  = 9'b001000000,
    S_ROOT = 9'b010000000,
    S_WB   = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  size_x, size_y, size_z;
  logic [31:0] inv_reynolds;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= 5'd16;
      size_y       <= 5'd16;
      size_z       <= 5'd16;
      inv_reynolds <= 32'h0001_0000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srms_pkg::REG_SIZE_X: size_x       <= cfg_data[4:0];
        srms_pkg::REG_SIZE_Y: size_y       <= cfg_data[4:0];
        srms_pkg::REG_SIZE_Z: size_z       <= cfg_data[4:0];
        srms_pkg::REG_INV_RE: inv_reynolds <= cfg_data;
        default: ;
      endcase
    end
  end

  // extents in use and item decode
  logic [DW-1:0] nx, ny, nz;
  logic          item_acc;
  logic          in_grid;
  logic          interior;
  logic [AW-1:0] item_addr;

  assign nx = srms_pkg::clamp_size(size_x, DW'(GRID_MAX_X));
  assign ny = srms_pkg::clamp_size(size_y, DW'(GRID_MAX_Y));
  assign nz = srms_pkg::clamp_size(size_z, DW'(GRID_MAX_Z));

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign in_grid    = (DW'(item.cell_x) < DW'(GRID_MAX_X)) &&
                      (DW'(item.cell_y) < DW'(GRID_MAX_Y)) &&
                      (DW'(item.cell_z) < DW'(GRID_MAX_Z));
  assign interior   = (item.cell_x != 4'd0) && (DW'(item.cell_x) <= nx - DW'(2)) &&
                      (item.cell_y != 4'd0) && (DW'(item.cell_y) <= ny - DW'(2)) &&
                      (item.cell_z != 4'd0) && (DW'(item.cell_z) <= nz - DW'(2));
  assign item_addr  = (AW'(item.cell_z) * AW'(GRID_MAX_Y) + AW'(item.cell_y))
                      * AW'(GRID_MAX_X) + AW'(item.cell_x);

  // stores
  logic          we_vel, we_csi, we_eta, we_zet, we_jm;
  logic [95:0]   vec_wdata;
  logic [AW-1:0] rd_addr;
  logic [95:0]   vel_rd, csi_rd, eta_rd, zet_rd;
  logic [34:0]   jm_rd;
  logic [AW-1:0] c_q;
  logic [2:0]    rd_cnt;

  assign vec_wdata = {item.value_z, item.value_y, item.value_x};
  assign we_vel = item_acc && in_grid && (item.cmd == srms_pkg::CMD_VEL);
  assign we_csi = item_acc && in_grid && (item.cmd == srms_pkg::CMD_CSI);
  assign we_eta = item_acc && in_grid && (item.cmd == srms_pkg::CMD_ETA);
  assign we_zet = item_acc && in_grid && (item.cmd == srms_pkg::CMD_ZET);
  assign we_jm  = item_acc && in_grid && (item.cmd == srms_pkg::CMD_JAC);

  srms_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_vel (
    .clk(clk), .we(we_vel), .waddr(item_addr), .wdata(vec_wdata),
    .raddr(rd_addr), .rdata(vel_rd)
  );
  srms_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_csi (
    .clk(clk), .we(we_csi), .waddr(item_addr), .wdata(vec_wdata),
    .raddr(rd_addr), .rdata(csi_rd)
  );
  srms_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_eta (
    .clk(clk), .we(we_eta), .waddr(item_addr), .wdata(vec_wdata),
    .raddr(rd_addr), .rdata(eta_rd)
  );
  srms_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_zet (
    .clk(clk), .we(we_zet), .waddr(item_addr), .wdata(vec_wdata),
    .raddr(rd_addr), .rdata(zet_rd)
  );
  srms_ram #(.WIDTH(35), .DEPTH(DEPTH)) u_jm (
    .clk(clk), .we(we_jm), .waddr(item_addr),
    .wdata({item.solid_mask, item.value_x}),
    .raddr(rd_addr), .rdata(jm_rd)
  );

  // stencil read order: centre, then low and high neighbour on each axis
  always_comb begin
    case (rd_cnt)
      3'd1:    rd_addr = c_q - STR_X;
      3'd2:    rd_addr = c_q + STR_X;
      3'd3:    rd_addr = c_q - STR_Y;
      3'd4:    rd_addr = c_q + STR_Y;
      3'd5:    rd_addr = c_q - STR_Z;
      3'd6:    rd_addr = c_q + STR_Z;
      default: rd_addr = c_q;
    endcase
  end

  // captured stencil
  logic [95:0]        vel_q   [7];
  logic [2:0]         mask_q  [7];
  logic [95:0]        metc_q  [3];
  logic [95:0]        metlo_q [3];
  logic signed [31:0] jac_q;
  logic [3:0]         pos_q   [3];
  logic [DW-1:0]      n_q     [3];
  logic [2:0]         slot;

  assign slot = rd_cnt - 3'd1;

  // gradients and averaged metrics
  logic signed [31:0] g_n    [9];
  logic signed [31:0] mavg_n [9];
  logic               grad_ovf;

  always_comb begin
    logic               lo_solid, hi_solid, fwd, bwd;
    logic signed [31:0] vc, vl, vh, mc, ml;
    logic signed [32:0] dd, ms;
    srms_pkg::sat_t     gs;
    grad_ovf = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo_solid = mask_q[1 + 2 * a] > srms_pkg::MASK_FLUID_MAX;
      hi_solid = mask_q[2 + 2 * a] > srms_pkg::MASK_FLUID_MAX;
      fwd = (pos_q[a] == 4'd1) || lo_solid;
      bwd = (DW'(pos_q[a]) == n_q[a] - DW'(2)) || hi_solid;
      for (int k = 0; k < 3; k++) begin
        vc = vel_q[0][32 * k +: 32];
        vl = vel_q[1 + 2 * a][32 * k +: 32];
        vh = vel_q[2 + 2 * a][32 * k +: 32];
        if (fwd) begin
          dd = 33'(vh) - 33'(vc);
        end else if (bwd) begin
          dd = 33'(vc) - 33'(vl);
        end else begin
          dd = (33'(vh) - 33'(vl)) >>> 1;
        end
        gs = srms_pkg::sat32(srms_pkg::SAT_W'(dd));
        g_n[3 * a + k] = gs.val;
        grad_ovf = grad_ovf | gs.ovf;
        mc = metc_q[a][32 * k +: 32];
        ml = metlo_q[a][32 * k +: 32];
        ms = 33'(mc) + 33'(ml);
        mavg_n[3 * a + k] = ms[32:1];
      end
    end
  end

  // products sequencer state
  logic signed [31:0] g_q    [9];
  logic signed [31:0] mavg_q [9];
  logic signed [31:0] met_q  [9];
  logic signed [31:0] d_q    [9];
  logic signed [31:0] a_q    [6];
  logic signed [49:0] acc_d;
  logic signed [srms_pkg::SAT_W-1:0] acc_i;
  logic [3:0]  c_j;
  logic [1:0]  c_r, c_k, c_ax;
  logic        iss_done;
  logic        pv;
  logic [3:0]  p_j;
  logic [1:0]  p_ax;
  logic        ovf;
  logic [31:0] pend_mag;
  logic [1:0]  pend_status;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               scl_ovf;

  srms_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // operand selection
  always_comb begin
    logic signed [32:0] ssum;
    srms_pkg::sat_t     ss;
    mul_a   = '0;
    mul_b   = '0;
    ssum    = '0;
    scl_ovf = 1'b0;
    case (state)
      S_MET: begin
        mul_a = 33'(mavg_q[c_j]);
        mul_b = 33'(jac_q);
      end
      S_DIF: begin
        mul_a = 33'(g_q[srms_pkg::idx3(c_ax, c_r)]);
        mul_b = 33'(met_q[srms_pkg::idx3(c_ax, c_k)]);
      end
      S_SCL: begin
        case (c_j)
          4'd0:    ssum = 33'(d_q[0]) + 33'(d_q[0]);
          4'd1:    ssum = 33'(d_q[4]) + 33'(d_q[4]);
          4'd2:    ssum = 33'(d_q[8]) + 33'(d_q[8]);
          4'd3:    ssum = 33'(d_q[1]) + 33'(d_q[3]);
          4'd4:    ssum = 33'(d_q[5]) + 33'(d_q[7]);
          4'd5:    ssum = 33'(d_q[2]) + 33'(d_q[6]);
          default: ssum = '0;
        endcase
        ss      = srms_pkg::sat32(srms_pkg::SAT_W'(ssum));
        scl_ovf = ss.ovf && !iss_done;
        mul_a   = 33'(ss.val);
        mul_b   = {1'b0, inv_reynolds};
      end
      S_INV: begin
        case (c_j)
          4'd0:    begin mul_a = 33'(a_q[0]); mul_b = 33'(a_q[0]); end
          4'd1:    begin mul_a = 33'(a_q[1]); mul_b = 33'(a_q[1]); end
          4'd2:    begin mul_a = 33'(a_q[2]); mul_b = 33'(a_q[2]); end
          4'd3:    begin mul_a = 33'(a_q[0]); mul_b = 33'(a_q[1]); end
          4'd4:    begin mul_a = 33'(a_q[1]); mul_b = 33'(a_q[2]); end
          4'd5:    begin mul_a = 33'(a_q[0]); mul_b = 33'(a_q[2]); end
          4'd6:    begin mul_a = 33'(a_q[3]); mul_b = 33'(a_q[3]); end
          4'd7:    begin mul_a = 33'(a_q[4]); mul_b = 33'(a_q[4]); end
          4'd8:    begin mul_a = 33'(a_q[5]); mul_b = 33'(a_q[5]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: ;
    endcase
  end

  // product consumption helpers
  logic signed [49:0] term;
  logic signed [49:0] acc_d_next;
  srms_pkg::sat_t     term_sat;
  srms_pkg::sat_t     accd_sat;
  logic [3:0]         last_j;
  logic               phase_end;

  assign term       = prod[65:16];
  assign acc_d_next = acc_d + term;
  assign term_sat   = srms_pkg::sat32(srms_pkg::SAT_W'(term));
  assign accd_sat   = srms_pkg::sat32(srms_pkg::SAT_W'(acc_d_next));
  assign last_j     = (state == S_SCL) ? 4'd5 : 4'd8;
  assign phase_end  = iss_done && !pv;

  // root unit
  srms_pkg::root_req_t root_req;
  srms_pkg::root_rsp_t root_rsp;

  assign root_req.start = (state == S_INV) && phase_end;
  assign root_req.value = acc_i[srms_pkg::SAT_W-1] ? '0 : acc_i[srms_pkg::INV_W-1:0];

  srms_root u_root (.clk(clk), .rst(rst), .req(root_req), .rsp(root_rsp));

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_cnt   <= '0;
      iss_done <= 1'b0;
      pv       <= 1'b0;
      c_j      <= '0;
      c_r      <= '0;
      c_k      <= '0;
      c_ax     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_acc && (item.cmd == srms_pkg::CMD_COMPUTE)) begin
            ovf      <= 1'b0;
            acc_d    <= '0;
            acc_i    <= '0;
            c_q      <= item_addr;
            pos_q[0] <= item.cell_x;
            pos_q[1] <= item.cell_y;
            pos_q[2] <= item.cell_z;
            n_q[0]   <= nx;
            n_q[1]   <= ny;
            n_q[2]   <= nz;
            rd_cnt   <= '0;
            if (interior) begin
              state <= S_READ;
            end else begin
              pend_mag    <= '0;
              pend_status <= srms_pkg::ST_EDGE;
              state       <= S_WB;
            end
          end
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt != 3'd0) begin
            vel_q[slot]  <= vel_rd;
            mask_q[slot] <= jm_rd[34:32];
            case (slot)
              3'd0: begin
                metc_q[0] <= csi_rd;
                metc_q[1] <= eta_rd;
                metc_q[2] <= zet_rd;
                jac_q     <= jm_rd[31:0];
              end
              3'd1:    metlo_q[0] <= csi_rd;
              3'd3:    metlo_q[1] <= eta_rd;
              3'd5:    metlo_q[2] <= zet_rd;
              default: ;
            endcase
          end
          if (rd_cnt == 3'd7) begin
            state <= S_GRAD;
          end
        end
        S_GRAD: begin
          for (int i = 0; i < 9; i++) begin
            g_q[i]    <= g_n[i];
            mavg_q[i] <= mavg_n[i];
          end
          ovf      <= ovf | grad_ovf;
          c_j      <= '0;
          iss_done <= 1'b0;
          pv       <= 1'b0;
          state    <= S_MET;
        end
        S_MET, S_DIF, S_SCL, S_INV: begin
          // issue side
          if (!iss_done) begin
            pv   <= 1'b1;
            p_j  <= c_j;
            p_ax <= c_ax;
            if (state == S_DIF) begin
              if (c_ax == 2'd2) begin
                c_ax <= '0;
                if (c_j == last_j) begin
                  iss_done <= 1'b1;
                end
                c_j <= c_j + 4'd1;
                if (c_k == 2'd2) begin
                  c_k <= '0;
                  c_r <= c_r + 2'd1;
                end else begin
                  c_k <= c_k + 2'd1;
                end
              end else begin
                c_ax <= c_ax + 2'd1;
              end
            end else begin
              if (c_j == last_j) begin
                iss_done <= 1'b1;
              end
              c_j <= c_j + 4'd1;
            end
            if (scl_ovf) begin
              ovf <= 1'b1;
            end
          end else begin
            pv <= 1'b0;
          end
          // consume side
          if (pv) begin
            case (state)
              S_MET: begin
                met_q[p_j] <= term_sat.val;
                if (term_sat.ovf) ovf <= 1'b1;
              end
              S_DIF: begin
                if (p_ax == 2'd2) begin
                  d_q[p_j] <= accd_sat.val;
                  acc_d    <= '0;
                  if (accd_sat.ovf) ovf <= 1'b1;
                end else begin
                  acc_d <= acc_d_next;
                end
              end
              S_SCL: begin
                a_q[p_j[2:0]] <= term_sat.val;
                if (term_sat.ovf) ovf <= 1'b1;
              end
              default: begin
                if (p_j < 4'd3) begin
                  acc_i <= acc_i + srms_pkg::SAT_W'(term);
                end else if (p_j < 4'd6) begin
                  acc_i <= acc_i - srms_pkg::SAT_W'(term);
                end else begin
                  acc_i <= acc_i + srms_pkg::SAT_W'(term)
                                 + (srms_pkg::SAT_W'(term) <<< 1);
                end
              end
            endcase
          end
          // phase hand-over
          if (phase_end) begin
            c_j      <= '0;
            c_r      <= '0;
            c_k      <= '0;
            c_ax     <= '0;
            iss_done <= 1'b0;
            case (state)
              S_MET:   state <= S_DIF;
              S_DIF:   state <= S_SCL;
              S_SCL:   state <= S_INV;
              default: state <= S_ROOT;
            endcase
          end
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            pend_mag    <= root_rsp.big ? 32'hFFFF_FFFF : root_rsp.mag;
            pend_status <= (ovf || root_rsp.big) ? srms_pkg::ST_SAT : srms_pkg::ST_OK;
            state       <= S_WB;
          end
        end
        S_WB: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  logic wb_go;
  assign wb_go = (state == S_WB) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (wb_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      result.strain_magnitude <= pend_mag;
      result.status           <= pend_status;
    end
  end

  // checks
  a_result_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_WB)
    else $error("result raised outside write-back");

  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    (we_vel || we_csi || we_eta || we_zet || we_jm) |-> state == S_IDLE)
    else $error("store written during a compute");

  a_root_start: assert property (@(posedge clk) disable iff (rst)
    root_req.start |=> state == S_ROOT)
    else $error("root unit started without waiting for it");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && root_rsp.done) |=> state == S_WB)
    else $error("root result not taken to write-back");

endmodule

`default_nettype wire
